/* hw/rtl/lbph_pkg.sv */
package lbph_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int IMG_WIDTH_W  = 9;
    localparam int IMG_HEIGHT_W = 11;
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 9'd200;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 11'd180;
    localparam int MIN_SIZE = 3;

    localparam int PIXEL_W     = 8;
    localparam int CODE_W      = 8;
    localparam int NUM_BINS    = 256;
    localparam int BIN_VALUE_W = 18;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COUNT_BITS = 18;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // latch the accepted item
        logic look;  // read line store, and the histogram for a bin read
        logic calc;  // form the code, read its bin, update line stores, advance window and counters
        logic emit;  // write the result register and the histogram
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
    } ctl_sts_t;

endpackage

/* hw/rtl/lbph_ctrl.sv */
module lbph_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  lbph_pkg::ctl_sts_t sts,
    output lbph_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb begin
        cmd.load = (state_reg == ST_IDLE) && s_valid;
        cmd.look = (state_reg == ST_LOOK);
        cmd.calc = (state_reg == ST_CALC);
        cmd.emit = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (sts.kind == lbph_pkg::KIND_PIXEL) begin
                        state_reg <= ST_CALC;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_CALC: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (cmd.emit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/lbph_datapath.sv */
module lbph_datapath #(
    parameter int MAX_WIDTH  = lbph_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbph_pkg::DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = lbph_pkg::DEF_COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lbph_pkg::ctl_cmd_t                  cmd,
    output lbph_pkg::ctl_sts_t                  sts,
    input  logic [1:0]                          s_kind,
    input  logic [lbph_pkg::PIXEL_W-1:0]        s_pixel,
    input  logic [lbph_pkg::CODE_W-1:0]         s_bin_index,
    input  logic                                cfg_we,
    input  logic [lbph_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lbph_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_code_valid,
    output logic [lbph_pkg::CODE_W-1:0]         m_lbp_code,
    output logic [lbph_pkg::BIN_VALUE_W-1:0]    m_bin_value,
    output logic                                m_frame_done
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int WSZ = ($clog2(MAX_WIDTH + 1) > lbph_pkg::IMG_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : lbph_pkg::IMG_WIDTH_W;
    localparam int HSZ = ($clog2(MAX_HEIGHT + 1) > lbph_pkg::IMG_HEIGHT_W) ?
                         $clog2(MAX_HEIGHT + 1) : lbph_pkg::IMG_HEIGHT_W;
    localparam int CNT_EXT = (COUNT_BITS > lbph_pkg::BIN_VALUE_W) ?
                             COUNT_BITS : lbph_pkg::BIN_VALUE_W;
    localparam logic [COUNT_BITS-1:0] BIN_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WSZ-1:0] MAXW_C = WSZ'(MAX_WIDTH);
    localparam logic [HSZ-1:0] MAXH_C = HSZ'(MAX_HEIGHT);
    localparam logic [WSZ-1:0] MINW_C = WSZ'(lbph_pkg::MIN_SIZE);
    localparam logic [HSZ-1:0] MINH_C = HSZ'(lbph_pkg::MIN_SIZE);

    localparam int PW = lbph_pkg::PIXEL_W;
    localparam int CW = lbph_pkg::CODE_W;

    // Configuration.
    logic [lbph_pkg::IMG_WIDTH_W-1:0]  img_width_reg;
    logic [lbph_pkg::IMG_HEIGHT_W-1:0] img_height_reg;

    // Latched item.
    logic [1:0]    kind_reg;
    logic [PW-1:0] pixel_reg;
    logic [CW-1:0] bin_idx_reg;

    // Raster position and window; slots 0..2 hold column c-1, 3..5 column c-2.
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [PW-1:0]       win_reg [6];

    // Line stores: top row and middle row.
    logic [PW-1:0] top_mem [MAX_WIDTH];
    logic [PW-1:0] mid_mem [MAX_WIDTH];
    logic [PW-1:0] top_rd_reg;
    logic [PW-1:0] mid_rd_reg;

    // Histogram with a valid bit per bin, so a clear needs no pass over the memory.
    logic [COUNT_BITS-1:0]         hist_mem [lbph_pkg::NUM_BINS];
    logic [lbph_pkg::NUM_BINS-1:0] hist_vld_reg;
    logic [COUNT_BITS-1:0]         hist_rd_reg;
    logic                          hist_rvld_reg;

    logic [CW-1:0] code_reg;
    logic          interior_reg;
    logic          done_reg;

    logic [CW-1:0] out_code_reg;
    logic          out_cvalid_reg;
    logic [lbph_pkg::BIN_VALUE_W-1:0] out_value_reg;
    logic          out_done_reg;

    logic [WSZ-1:0]      w_raw, w_eff, c_ext, c_lim;
    logic [HSZ-1:0]      h_raw, h_eff, r_ext, r_lim;
    logic [COL_BITS-1:0] c_eff;
    logic [ROW_BITS-1:0] r_eff;
    logic                last_col, last_row, interior;
    logic [PW-1:0]       ctr;
    logic [CW-1:0]       code_next;
    logic [CW-1:0]       hist_raddr;
    logic                hist_we;
    logic                clear_go;
    logic [COUNT_BITS-1:0] cnt_cur, cnt_new;
    logic [CNT_EXT-1:0]    cnt_cur_ext, cnt_new_ext;

    assign sts.kind = kind_reg;

    // Sizes clamped to the supported range; counters past the end count as the end.
    always_comb begin
        w_raw = WSZ'(img_width_reg);
        h_raw = HSZ'(img_height_reg);
        if (w_raw < MINW_C) begin
            w_eff = MINW_C;
        end else if (w_raw > MAXW_C) begin
            w_eff = MAXW_C;
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < MINH_C) begin
            h_eff = MINH_C;
        end else if (h_raw > MAXH_C) begin
            h_eff = MAXH_C;
        end else begin
            h_eff = h_raw;
        end
        c_ext = WSZ'(col_reg);
        r_ext = HSZ'(row_reg);
        c_lim = (c_ext > w_eff - WSZ'(1)) ? w_eff - WSZ'(1) : c_ext;
        r_lim = (r_ext > h_eff - HSZ'(1)) ? h_eff - HSZ'(1) : r_ext;
        c_eff = c_lim[COL_BITS-1:0];
        r_eff = r_lim[ROW_BITS-1:0];
        last_col = (c_lim == w_eff - WSZ'(1));
        last_row = (r_lim == h_eff - HSZ'(1));
        interior = (c_lim >= WSZ'(2)) && (r_lim >= HSZ'(2));
    end

    // Pattern code: a bit is set where the centre is below that neighbour.
    always_comb begin
        ctr = win_reg[1];
        code_next[0] = ctr < win_reg[4];
        code_next[1] = ctr < win_reg[5];
        code_next[2] = ctr < win_reg[2];
        code_next[3] = ctr < pixel_reg;
        code_next[4] = ctr < mid_rd_reg;
        code_next[5] = ctr < top_rd_reg;
        code_next[6] = ctr < win_reg[0];
        code_next[7] = ctr < win_reg[3];
    end

    assign hist_raddr = cmd.calc ? code_next : bin_idx_reg;
    assign clear_go   = cmd.emit && (kind_reg == lbph_pkg::KIND_CLEAR);
    assign hist_we    = cmd.emit && (kind_reg == lbph_pkg::KIND_PIXEL) && interior_reg;

    // Saturating increment of the bin read in the calculation step.
    always_comb begin
        cnt_cur = hist_rvld_reg ? hist_rd_reg : '0;
        cnt_new = (cnt_cur != BIN_MAX) ? cnt_cur + COUNT_BITS'(1) : cnt_cur;
        cnt_cur_ext = CNT_EXT'(cnt_cur);
        cnt_new_ext = CNT_EXT'(cnt_new);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg  <= lbph_pkg::IMG_WIDTH_RESET;
            img_height_reg <= lbph_pkg::IMG_HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == lbph_pkg::CFG_IMAGE_WIDTH) begin
                img_width_reg <= cfg_data[lbph_pkg::IMG_WIDTH_W-1:0];
            end else begin
                img_height_reg <= cfg_data[lbph_pkg::IMG_HEIGHT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_kind;
            pixel_reg   <= s_pixel;
            bin_idx_reg <= s_bin_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            top_rd_reg <= top_mem[c_eff];
            mid_rd_reg <= mid_mem[c_eff];
        end
        if (cmd.calc) begin
            top_mem[c_eff] <= mid_rd_reg;
            mid_mem[c_eff] <= pixel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.look || cmd.calc) begin
            hist_rd_reg   <= hist_mem[hist_raddr];
            hist_rvld_reg <= hist_vld_reg[hist_raddr];
        end
        if (hist_we) begin
            hist_mem[code_reg] <= cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
        end else if (clear_go) begin
            hist_vld_reg <= '0;
        end else if (hist_we) begin
            hist_vld_reg[code_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear_go) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.calc) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top_rd_reg;
            win_reg[1] <= mid_rd_reg;
            win_reg[2] <= pixel_reg;
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : r_eff + ROW_BITS'(1);
            end else begin
                col_reg <= c_eff + COL_BITS'(1);
                row_reg <= r_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            code_reg     <= code_next;
            interior_reg <= interior;
            done_reg     <= last_col && last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            unique case (kind_reg)
                lbph_pkg::KIND_PIXEL: begin
                    out_cvalid_reg <= interior_reg;
                    out_code_reg   <= interior_reg ? code_reg : '0;
                    out_value_reg  <= interior_reg ?
                                      cnt_new_ext[lbph_pkg::BIN_VALUE_W-1:0] : '0;
                    out_done_reg   <= done_reg;
                end
                lbph_pkg::KIND_READ: begin
                    out_cvalid_reg <= 1'b0;
                    out_code_reg   <= '0;
                    out_value_reg  <= cnt_cur_ext[lbph_pkg::BIN_VALUE_W-1:0];
                    out_done_reg   <= 1'b0;
                end
                default: begin
                    out_cvalid_reg <= 1'b0;
                    out_code_reg   <= '0;
                    out_value_reg  <= '0;
                    out_done_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign m_code_valid = out_cvalid_reg;
    assign m_lbp_code   = out_code_reg;
    assign m_bin_value  = out_value_reg;
    assign m_frame_done = out_done_reg;

endmodule

/* hw/rtl/lbp_histogram_core.sv */
// Local binary pattern histogram over a raster stream of 8-bit pixels. Each input item is
// a pixel (kind 0), a bin read (kind 1) or a histogram clear with frame restart (kind 2);
// every item gives exactly one result item. For a pixel that completes an interior 3x3
// window the result carries the pattern code of the window centre and the bin count after
// its saturating increment; a bin read returns that bin's count. The block handles one
// item at a time: a pixel passes through the look, calculation and emit steps before its
// result is in the result register, while a bin read or any other kind skips the
// calculation step; no new item is taken until the current one has been emitted.
// The steps are set by the single-port line store read, followed by the read-modify-write
// of the single-port histogram memory. A finished result waits in an output register, so
// the next item is taken while it is still pending; a result that cannot be written
// because the previous one has not been taken stalls the block until it is. The
// histogram clear resets all the per-bin valid flags at once, and no clearing pass
// follows reset. Configuration writes are always accepted and must only be made while
// the block is idle.
module lbp_histogram_core #(
    parameter int MAX_WIDTH  = lbph_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbph_pkg::DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = lbph_pkg::DEF_COUNT_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input items.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_kind,
    input  logic [lbph_pkg::PIXEL_W-1:0]     s_pixel,
    input  logic [lbph_pkg::CODE_W-1:0]      s_bin_index,
    // Result items.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_code_valid,
    output logic [lbph_pkg::CODE_W-1:0]      m_lbp_code,
    output logic [lbph_pkg::BIN_VALUE_W-1:0] m_bin_value,
    output logic                             m_frame_done,
    // Configuration writes: index 0 image width, index 1 image height.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lbph_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbph_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lbph_pkg::ctl_cmd_t cmd;
    lbph_pkg::ctl_sts_t sts;

    // Register writes need no handshake back-pressure.
    assign cfg_ready = 1'b1;

    lbph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lbph_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_kind       (s_kind),
        .s_pixel      (s_pixel),
        .s_bin_index  (s_bin_index),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_code_valid (m_code_valid),
        .m_lbp_code   (m_lbp_code),
        .m_bin_value  (m_bin_value),
        .m_frame_done (m_frame_done)
    );

`ifndef SYNTH
    // Only one item is in flight: after acceptance the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in progress");

    // The last pixel of a frame is always an interior window centre.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> m_code_valid)
        else $error("frame end reported without a counted code");

    // Without a counted code the code field is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_code_valid) |-> (m_lbp_code == '0))
        else $error("pattern code present without code_valid");
`endif

endmodule

/* dv/lbph_checker.sv */
// Watches the three channels of the pattern histogram core, predicts one result per accepted
// item and compares the results in order.
module lbph_checker
    import lbph_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [PIXEL_W-1:0]       s_pixel,
    input  logic [CODE_W-1:0]        s_bin_index,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_code_valid,
    input  logic [CODE_W-1:0]        m_lbp_code,
    input  logic [BIN_VALUE_W-1:0]   m_bin_value,
    input  logic                     m_frame_done,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       fail_total,
    output int                       expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH  = DEF_MAX_WIDTH;
    localparam int MAX_HEIGHT = DEF_MAX_HEIGHT;
    localparam int COUNT_BITS = DEF_COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] BIN_MAX = '1;

    typedef struct packed {
        logic                   code_valid;
        logic [CODE_W-1:0]      code;
        logic [BIN_VALUE_W-1:0] count;
        logic                   frame_done;
    } lbp_result_t;

    lbp_result_t lbp_expected_q[$];
    lbp_result_t want;

    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic [PIXEL_W-1:0]      line_mem [2*MAX_WIDTH];
    logic [PIXEL_W-1:0]      win [6];
    logic [COUNT_BITS-1:0]   hist [NUM_BINS];
    int unsigned             col_pos;
    int unsigned             row_pos;
    int                      fail_count = 0;
    int                      queue_depth = 0;

    assign fail_total    = fail_count;
    assign expected_left = queue_depth;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Empties the histogram and restarts the frame; the line store keeps its contents.
    function automatic void clear_counts();
        foreach (hist[i]) hist[i] = '0;
        foreach (win[i]) win[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic lbp_result_t step_lbp(input logic [1:0] kind,
                                             input logic [PIXEL_W-1:0] pix,
                                             input logic [CODE_W-1:0] bin);
        lbp_result_t res;
        int unsigned w, h, c, r;
        logic [PIXEL_W-1:0] top, mid, ctr;
        logic [CODE_W-1:0] k;
        res = '0;
        case (kind)
            KIND_PIXEL: begin
                w = clamp_dim(32'(width_reg), MAX_WIDTH);
                h = clamp_dim(32'(height_reg), MAX_HEIGHT);
                // A counter left past the end by a smaller size counts as the last position.
                c = (col_pos > w - 1) ? w - 1 : col_pos;
                r = (row_pos > h - 1) ? h - 1 : row_pos;
                top = line_mem[MAX_WIDTH + c];
                mid = line_mem[c];
                if (r >= 2 && c >= 2) begin
                    ctr = win[1];
                    k = {ctr < win[3], ctr < win[0], ctr < top, ctr < mid,
                         ctr < pix, ctr < win[2], ctr < win[5], ctr < win[4]};
                    if (hist[k] != BIN_MAX) hist[k] = hist[k] + 1'b1;
                    res.code_valid = 1'b1;
                    res.code = k;
                    res.count = hist[k];
                end
                win[3] = win[0];
                win[4] = win[1];
                win[5] = win[2];
                win[0] = top;
                win[1] = mid;
                win[2] = pix;
                line_mem[MAX_WIDTH + c] = mid;
                line_mem[c] = pix;
                res.frame_done = (c == w - 1) && (r == h - 1);
                if (c == w - 1) begin
                    col_pos = 0;
                    row_pos = (r == h - 1) ? 0 : r + 1;
                end else begin
                    col_pos = c + 1;
                    row_pos = r;
                end
            end
            KIND_READ: res.count = hist[bin];
            KIND_CLEAR: clear_counts();
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = IMG_WIDTH_RESET;
            height_reg = IMG_HEIGHT_RESET;
            foreach (line_mem[i]) line_mem[i] = '0;
            clear_counts();
            lbp_expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IMAGE_WIDTH) width_reg = cfg_data[IMG_WIDTH_W-1:0];
                else height_reg = cfg_data[IMG_HEIGHT_W-1:0];
            end
            if (s_valid && s_ready)
                lbp_expected_q.push_back(step_lbp(s_kind, s_pixel, s_bin_index));
            if (m_valid && m_ready) begin
                if (lbp_expected_q.size() == 0) begin
                    $error("result item arrived with no expected item waiting");
                    fail_count++;
                end else begin
                    want = lbp_expected_q.pop_front();
                    if (m_code_valid !== want.code_valid) begin
                        $error("code_valid: expected %0d, actual %0d", want.code_valid,
                               m_code_valid);
                        fail_count++;
                    end
                    if (m_lbp_code !== want.code) begin
                        $error("lbp_code: expected %0d, actual %0d", want.code, m_lbp_code);
                        fail_count++;
                    end
                    if (m_bin_value !== want.count) begin
                        $error("bin_value: expected %0d, actual %0d", want.count, m_bin_value);
                        fail_count++;
                    end
                    if (m_frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0d, actual %0d", want.frame_done,
                               m_frame_done);
                        fail_count++;
                    end
                end
            end
        end
        queue_depth = lbp_expected_q.size();
    end

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbph_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung. The longest
    // legitimate quiet stretch is the deliberate receiver hold below, plus the
    // time the block takes to pass an item through.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1700;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_kind = KIND_PIXEL;
    logic [PIXEL_W-1:0]     s_pixel = '0;
    logic [CODE_W-1:0]      s_bin_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_code_valid;
    logic [CODE_W-1:0]      m_lbp_code;
    logic [BIN_VALUE_W-1:0] m_bin_value;
    logic                   m_frame_done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_total;
    int expected_left;
    int send_idle_pct = 18;
    int recv_idle_pct = 67;
    int hold_len = 0;
    int quiet_cycles = 0;
    int fed_items = 0;
    int cur_width = 32'(IMG_WIDTH_RESET);

    lbp_histogram_core dut (.*);

    lbph_checker chk (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver decides readiness once per cycle on the falling edge. When a
    // hold is requested it keeps ready low for the whole stretch, so that the
    // output register fills, the block stalls and the sender is pushed back.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic int clamp_size(input int v, input int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Pixel values: mostly uniform, often from a tiny range so that equal
    // neighbours (which must not set a bit) are common, sometimes the extremes.
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return PIXEL_W'($urandom_range(255));
        if (sel < 8) return PIXEL_W'($urandom_range(3));
        return sel[0] ? 8'hFF : 8'h00;
    endfunction

    // Offers one item and returns at the falling edge after it has been taken.
    // Valid is left high so that a following item goes out without a gap; it
    // is lowered only for a random idle cycle or at the end of a phase.
    task automatic put_item(input logic [1:0] kind, input logic [PIXEL_W-1:0] pix,
                            input logic [CODE_W-1:0] bin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_pixel <= pix;
        s_bin_index <= bin;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stops offering and waits until every expected result has been taken, which
    // leaves the block idle because every item produces exactly one result.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
        cur_width = clamp_size(w, DEF_MAX_WIDTH);
    endtask

    // A well-formed stream: mostly pixels, with the odd bin read, clear and
    // ignored kind mixed in. Ignored items do not count towards the total.
    task automatic stream(input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 88)
                put_item(KIND_PIXEL, pick_pixel(), CODE_W'($urandom_range(255)));
            else if (sel < 95)
                put_item(KIND_READ, PIXEL_W'($urandom_range(255)),
                         CODE_W'($urandom_range(255)));
            else if (sel < 97)
                put_item(KIND_CLEAR, PIXEL_W'($urandom_range(255)),
                         CODE_W'($urandom_range(255)));
            else
                put_item(KIND_UNUSED, PIXEL_W'($urandom_range(255)),
                         CODE_W'($urandom_range(255)));
            if (sel < 97) fed_items++;
        end
    endtask

    // One small image size and one to three frames' worth of items. A wider
    // image is only set up straight after a clear, so that the first two rows
    // refill the line store before any code reads it; a narrower one may land
    // in mid-frame, which leaves the counters past the new end.
    task automatic small_segment();
        int w, h, ew, frame_len;
        w = ($urandom_range(19) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
        h = $urandom_range(7);
        ew = clamp_size(w, DEF_MAX_WIDTH);
        if (ew > cur_width || $urandom_range(3) == 0)
            put_item(KIND_CLEAR, PIXEL_W'($urandom_range(255)),
                     CODE_W'($urandom_range(255)));
        drain();
        set_size(w, h);
        frame_len = ew * clamp_size(h, DEF_MAX_HEIGHT);
        stream(frame_len * $urandom_range(1, 2) + $urandom_range(frame_len));
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A 3x3 frame whose centre is darker than all eight
        // neighbours gives the all-ones code on its last pixel, which also ends
        // the frame.
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            put_item(KIND_PIXEL, (i == 4) ? 8'h00 : 8'hFF, 8'h00);
        put_item(KIND_READ, 8'h00, 8'hFF);
        put_item(KIND_READ, 8'hFF, 8'h00);
        put_item(KIND_UNUSED, 8'hAA, 8'h55);
        drain();
        // Sizes below the minimum are clamped to 3, so this is a 3x3 frame again;
        // a flat frame checks that equal neighbours leave every bit clear.
        set_size(0, 2);
        for (int i = 0; i < 9; i++)
            put_item(KIND_PIXEL, 8'h80, 8'hAA);
        put_item(KIND_CLEAR, 8'h55, 8'hAA);
        put_item(KIND_READ, 8'h00, 8'h00);
        drain();

        // Sender idles a little, receiver a lot.
        while (fed_items < 450) small_segment();

        // Now the other way round. The height is first set far above its limit
        // and left in mid-frame, so a later smaller height finds the row
        // counter beyond the last row.
        send_idle_pct = 67;
        recv_idle_pct = 18;
        drain();
        set_size(3, 2047);
        stream(90);
        while (fed_items < 900) small_segment();

        // No idling at all. One full frame at the widest clamped size, with the
        // receiver holding off for a long stretch at its start while the sender
        // keeps offering pixels.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        put_item(KIND_CLEAR, 8'h00, 8'h00);
        drain();
        set_size(511, 3);
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 770; i++)
            put_item(KIND_PIXEL, pick_pixel(), CODE_W'($urandom_range(255)));
        fed_items += 770;
        while (fed_items < RANDOM_ITEMS) small_segment();

        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_total == 0 && expected_left == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
